FILE: design/page_framebuffer_draw_engine_unit_assert.svh
// assertion macros used by the draw engine checker
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_UNIT_ASSERT_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_UNIT_ASSERT_SVH

// plain clocked assertion, also checked while reset is high
`define PFDE_ASSERT_SYNC(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// clocked assertion switched off while reset is high
`define PFDE_ASSERT_LIVE(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

FILE: design/pfde_pkg.sv
// shared constants, types and helper functions of the page framebuffer draw engine
package pfde_pkg;

   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;
   localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;

   localparam int ADDR_W  = $clog2(STORE_BYTES);
   localparam int COL_W   = $clog2(SCREEN_WIDTH);
   localparam int ROW_W   = $clog2(SCREEN_HEIGHT);
   localparam int PAGE_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

   localparam int COORD_W    = 16;
   localparam int IDX_W      = 10;
   localparam int REQ_DATA_W = 80;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_PAD_W  = RSP_DATA_W - 9;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] BYTE_ONES    = 8'hFF;
   localparam logic [2:0] PAGE_BIT_TOP = 3'd7;

   typedef enum logic [2:0] {
      OP_SET_PIXEL    = 3'd0,
      OP_GET_PIXEL    = 3'd1,
      OP_FILL_SCREEN  = 3'd2,
      OP_FILL_RECT    = 3'd3,
      OP_OUTLINE_RECT = 3'd4,
      OP_READ_BYTE    = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      K_NONE,
      K_SPAN,
      K_OUTLINE,
      K_SCREEN,
      K_GET_PIXEL,
      K_GET_BYTE
   } kind_type;

   typedef enum logic [1:0] {
      PH_TOP,
      PH_BOTTOM,
      PH_LEFT,
      PH_RIGHT
   } phase_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_START,
      B_SPAN,
      B_DRAIN,
      B_SWEEP,
      B_READ,
      B_FINISH
   } back_state_type;

   typedef struct packed {
      kind_type            kind;
      logic [COL_W-1:0]    c0;
      logic [COL_W-1:0]    c1;
      logic [ROW_W-1:0]    r0;
      logic [ROW_W-1:0]    r1;
      logic                value;
      logic [ADDR_W-1:0]   addr;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   function automatic logic [COL_W-1:0] clamp_col(input logic signed [COORD_W-1:0] v);
      logic [COL_W-1:0] r;
      if (v < $signed(COORD_W'(0))) begin
         r = '0;
      end else if (v > $signed(COORD_W'(SCREEN_WIDTH - 1))) begin
         r = COL_W'(SCREEN_WIDTH - 1);
      end else begin
         r = v[COL_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [ROW_W-1:0] clamp_row(input logic signed [COORD_W-1:0] v);
      logic [ROW_W-1:0] r;
      if (v < $signed(COORD_W'(0))) begin
         r = '0;
      end else if (v > $signed(COORD_W'(SCREEN_HEIGHT - 1))) begin
         r = ROW_W'(SCREEN_HEIGHT - 1);
      end else begin
         r = v[ROW_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [PAGE_W-1:0] page_of(input logic [ROW_W-1:0] row);
      return PAGE_W'(row >> 3);
   endfunction

   function automatic logic [ADDR_W-1:0] byte_addr(input logic [COL_W-1:0] col,
                                                   input logic [PAGE_W-1:0] page);
      return ADDR_W'(col) + ADDR_W'(page) * ADDR_W'(SCREEN_WIDTH);
   endfunction

   function automatic logic [7:0] page_mask(input logic [2:0] lo, input logic [2:0] hi);
      return (BYTE_ONES << lo) & (BYTE_ONES >> (PAGE_BIT_TOP - hi));
   endfunction

endpackage

FILE: design/page_framebuffer_draw_engine_unit.sv
// top level of the page framebuffer draw engine: front end, work queue, back end
// fill rect walks each column of each page it covers; an outline walks four such spans
// throughput is set by the read-modify-write memory path, one byte per cycle while a span runs
// the front end takes up to two items ahead while the back end works
// reset clears the framebuffer in a pass over all 1024 bytes during which req_tready stays low
module page_framebuffer_draw_engine_unit import pfde_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // col_a[15:0] col_b[31:16] row_a[47:32] row_b[63:48] draw_value[64] byte_index[74:65]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode[2:0]
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pixel_value[0] read_data[8:1]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   queue_status_type q_status;
   back_status_type  b_status;
   logic             push;
   entry_type        push_entry;
   logic             pop;
   entry_type        pop_entry;

   pfde_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .b_status   (b_status),
      .push       (push),
      .push_entry (push_entry)
   );

   pfde_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   pfde_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_entry    (pop_entry),
      .q_status   (q_status),
      .pop        (pop),
      .b_status   (b_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: design/pfde_front.sv
// front end: accepts request items, clamps coordinates and classifies the work
module pfde_front import pfde_pkg::*; (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // col_a[15:0] col_b[31:16] row_a[47:32] row_b[63:48] draw_value[64] byte_index[74:65]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode[2:0]
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  queue_status_type      q_status,
   input  back_status_type       b_status,
   output logic                  push,
   output entry_type             push_entry
);

   logic signed [COORD_W-1:0] col_a;
   logic signed [COORD_W-1:0] col_b;
   logic signed [COORD_W-1:0] row_a;
   logic signed [COORD_W-1:0] row_b;
   logic                      draw_value;
   logic [IDX_W-1:0]          byte_index;
   logic [COL_W-1:0]          ca;
   logic [COL_W-1:0]          cb;
   logic [ROW_W-1:0]          ra;
   logic [ROW_W-1:0]          rb;
   logic                      pixel_on_screen;
   logic                      index_in_store;

   assign col_a      = $signed(req_tdata[15:0]);
   assign col_b      = $signed(req_tdata[31:16]);
   assign row_a      = $signed(req_tdata[47:32]);
   assign row_b      = $signed(req_tdata[63:48]);
   assign draw_value = req_tdata[64];
   assign byte_index = req_tdata[74:65];

   assign ca = clamp_col(col_a);
   assign cb = clamp_col(col_b);
   assign ra = clamp_row(row_a);
   assign rb = clamp_row(row_b);

   assign pixel_on_screen = !col_a[COORD_W-1] && !row_a[COORD_W-1]
                         && (col_a < $signed(COORD_W'(SCREEN_WIDTH)))
                         && (row_a < $signed(COORD_W'(SCREEN_HEIGHT)));
   assign index_in_store  = 32'(byte_index) < 32'(STORE_BYTES);

   assign req_tready = !q_status.full && !b_status.clearing;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      push_entry.kind  = K_NONE;
      push_entry.c0    = (ca < cb) ? ca : cb;
      push_entry.c1    = (ca < cb) ? cb : ca;
      push_entry.r0    = (ra < rb) ? ra : rb;
      push_entry.r1    = (ra < rb) ? rb : ra;
      push_entry.value = draw_value;
      push_entry.addr  = ADDR_W'(byte_index);
      case (opcode_type'(req_tuser))
         OP_SET_PIXEL: begin
            push_entry.c0 = ca;
            push_entry.c1 = ca;
            push_entry.r0 = ra;
            push_entry.r1 = ra;
            if (pixel_on_screen) begin
               push_entry.kind = K_SPAN;
            end
         end
         OP_GET_PIXEL: begin
            push_entry.c0 = ca;
            push_entry.r0 = ra;
            if (pixel_on_screen) begin
               push_entry.kind = K_GET_PIXEL;
            end
         end
         OP_FILL_SCREEN: begin
            push_entry.kind = K_SCREEN;
         end
         OP_FILL_RECT: begin
            push_entry.kind = K_SPAN;
         end
         OP_OUTLINE_RECT: begin
            push_entry.kind = K_OUTLINE;
         end
         OP_READ_BYTE: begin
            if (index_in_store) begin
               push_entry.kind = K_GET_BYTE;
            end
         end
         default: begin
            push_entry.kind = K_NONE;
         end
      endcase
   end

endmodule

FILE: design/pfde_queue.sv
// short work queue between the front end and the drawing back end
module pfde_queue import pfde_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        pop_entry,
   output queue_status_type status
);

   entry_type         slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry    = slots_ff[rd_ptr_ff];
   assign status.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;

endmodule

FILE: design/pfde_back.sv
// back end: framebuffer memory, span and sweep sequencer, result register
module pfde_back import pfde_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  entry_type             q_entry,
   input  queue_status_type      q_status,
   output logic                  pop,
   output back_status_type       b_status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pixel_value[0] read_data[8:1]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [7:0]        frame_ff [STORE_BYTES];
   logic [7:0]        rd_data_ff;

   back_state_type    state_ff;
   back_state_type    state_in;
   entry_type         cur_ff;
   entry_type         cur_in;
   phase_type         phase_ff;
   phase_type         phase_in;
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [PAGE_W-1:0] page_ff;
   logic [PAGE_W-1:0] page_in;
   logic [ADDR_W-1:0] sweep_ff;
   logic [ADDR_W-1:0] sweep_in;
   logic              wr_valid_ff;
   logic              wr_valid_in;
   logic [ADDR_W-1:0] wr_addr_ff;
   logic [ADDR_W-1:0] wr_addr_in;
   logic [7:0]        wr_mask_ff;
   logic [7:0]        wr_mask_in;
   logic              res_pix_ff;
   logic              res_pix_in;
   logic [7:0]        res_data_ff;
   logic [7:0]        res_data_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic              out_pix_ff;
   logic              out_pix_in;
   logic [7:0]        out_data_ff;
   logic [7:0]        out_data_in;

   logic [COL_W-1:0]  span_c0;
   logic [COL_W-1:0]  span_c1;
   logic [ROW_W-1:0]  span_r0;
   logic [ROW_W-1:0]  span_r1;
   logic [PAGE_W-1:0] p0;
   logic [PAGE_W-1:0] p1;
   logic [2:0]        lo_bit;
   logic [2:0]        hi_bit;
   logic [7:0]        span_mask;
   logic [ADDR_W-1:0] cur_addr;
   logic              sweep_last;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;

   // bounds of the span worked on now; an outline walks four spans
   always_comb begin
      span_c0 = cur_ff.c0;
      span_c1 = cur_ff.c1;
      span_r0 = cur_ff.r0;
      span_r1 = cur_ff.r1;
      if (cur_ff.kind == K_OUTLINE) begin
         case (phase_ff)
            PH_TOP:    span_r1 = cur_ff.r0;
            PH_BOTTOM: span_r0 = cur_ff.r1;
            PH_LEFT:   span_c1 = cur_ff.c0;
            default:   span_c0 = cur_ff.c1;
         endcase
      end
   end

   assign p0        = page_of(span_r0);
   assign p1        = page_of(span_r1);
   assign lo_bit    = (page_ff == p0) ? span_r0[2:0] : 3'd0;
   assign hi_bit    = (page_ff == p1) ? span_r1[2:0] : PAGE_BIT_TOP;
   assign span_mask = page_mask(lo_bit, hi_bit);
   assign cur_addr  = byte_addr(col_ff, page_ff);
   assign sweep_last = sweep_ff == ADDR_W'(STORE_BYTES - 1);

   // memory ports
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wr_addr_ff;
      mem_wdata = cur_ff.value ? (rd_data_ff | wr_mask_ff) : (rd_data_ff & ~wr_mask_ff);
      if (state_ff == B_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_ff;
         mem_wdata = 8'h00;
      end else if (state_ff == B_SWEEP) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_ff;
         mem_wdata = cur_ff.value ? BYTE_ONES : 8'h00;
      end else if (wr_valid_ff) begin
         mem_we    = 1'b1;
      end
      mem_raddr = cur_addr;
      if (state_ff == B_START) begin
         if (cur_ff.kind == K_GET_BYTE) begin
            mem_raddr = cur_ff.addr;
         end else begin
            mem_raddr = byte_addr(cur_ff.c0, page_of(cur_ff.r0));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= frame_ff[mem_raddr];
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      phase_in     = phase_ff;
      col_in       = col_ff;
      page_in      = page_ff;
      sweep_in     = sweep_ff;
      wr_valid_in  = 1'b0;
      wr_addr_in   = wr_addr_ff;
      wr_mask_in   = wr_mask_ff;
      res_pix_in   = res_pix_ff;
      res_data_in  = res_data_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_pix_in   = out_pix_ff;
      out_data_in  = out_data_ff;
      pop          = 1'b0;
      case (state_ff)
         B_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last) begin
               sweep_in = '0;
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               cur_in   = q_entry;
               phase_in = PH_TOP;
               state_in = B_START;
            end
         end
         B_START: begin
            res_pix_in  = 1'b0;
            res_data_in = 8'h00;
            case (cur_ff.kind)
               K_SPAN, K_OUTLINE: begin
                  col_in   = span_c0;
                  page_in  = p0;
                  state_in = B_SPAN;
               end
               K_SCREEN: begin
                  sweep_in = '0;
                  state_in = B_SWEEP;
               end
               K_GET_PIXEL, K_GET_BYTE: begin
                  state_in = B_READ;
               end
               default: begin
                  state_in = B_FINISH;
               end
            endcase
         end
         B_SPAN: begin
            // read this byte now, write it back next cycle
            wr_valid_in = 1'b1;
            wr_addr_in  = cur_addr;
            wr_mask_in  = span_mask;
            if (col_ff == span_c1) begin
               col_in = span_c0;
               if (page_ff == p1) begin
                  state_in = B_DRAIN;
               end else begin
                  page_in = page_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         B_DRAIN: begin
            if (cur_ff.kind == K_OUTLINE && phase_ff != PH_RIGHT) begin
               phase_in = phase_type'(phase_ff + 2'd1);
               state_in = B_START;
            end else begin
               state_in = B_FINISH;
            end
         end
         B_SWEEP: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last) begin
               state_in = B_FINISH;
            end
         end
         B_READ: begin
            if (cur_ff.kind == K_GET_BYTE) begin
               res_data_in = rd_data_ff;
            end else begin
               res_pix_in = rd_data_ff[cur_ff.r0[2:0]];
            end
            state_in = B_FINISH;
         end
         B_FINISH: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_pix_in   = res_pix_ff;
               out_data_in  = res_data_ff;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         phase_ff     <= PH_TOP;
         sweep_ff     <= '0;
         wr_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         sweep_ff     <= sweep_in;
         wr_valid_ff  <= wr_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      col_ff      <= col_in;
      page_ff     <= page_in;
      wr_addr_ff  <= wr_addr_in;
      wr_mask_ff  <= wr_mask_in;
      res_pix_ff  <= res_pix_in;
      res_data_ff <= res_data_in;
      out_pix_ff  <= out_pix_in;
      out_data_ff <= out_data_in;
   end

   assign b_status.clearing = state_ff == B_CLEAR;
   assign rsp_tvalid        = out_valid_ff;
   assign rsp_tdata         = {{RSP_PAD_W{1'b0}}, out_data_ff, out_pix_ff};

endmodule

FILE: design/pfde_checker.sv
// port-level checker of the draw engine and its bind to the top level
`include "page_framebuffer_draw_engine_unit_assert.svh"

module pfde_checker import pfde_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // clearing pass follows reset
   `PFDE_ASSERT_SYNC(a_busy_after_reset, clock, reset |=> !req_tready, "ready high after reset")
   `PFDE_ASSERT_SYNC(a_quiet_after_reset, clock, reset |=> !rsp_tvalid, "result after reset")
   `PFDE_ASSERT_LIVE(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   // a result carries a pixel or a byte, never both
   `PFDE_ASSERT_LIVE(a_one_field, clock, reset,
      rsp_tvalid |-> !(rsp_tdata[0] && (rsp_tdata[8:1] != 8'h00)), "pixel and byte both set")

endmodule

bind page_framebuffer_draw_engine_unit pfde_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: bench/testbench.sv
// self-checking bench for the page framebuffer draw engine: queued stimulus, predictor, scoreboard
module testbench;
   import pfde_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int RANDOM_ITEMS = 580;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AFTER   = 150;
   localparam int TAIL_CYCLES  = 64;

   typedef struct {
      logic [2:0]         op;
      logic signed [15:0] col_a;
      logic signed [15:0] col_b;
      logic signed [15:0] row_a;
      logic signed [15:0] row_b;
      logic               draw_value;
      logic [9:0]         byte_index;
   } draw_req_type;

   typedef struct {
      logic       pixel_value;
      logic [7:0] read_data;
   } readback_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   draw_req_type pending_reqs[$];
   readback_type expected_readback[$];
   logic [7:0] frame_model [STORE_BYTES];
   draw_req_type on_wire;

   int error_count = 0;
   int items_taken = 0;
   int results_seen = 0;
   int op_count [8];
   int burst_left = 1;
   int gap_left = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   int ready_cycle = 0;

   page_framebuffer_draw_engine_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int clamp_to(int v, int top);
      if (v < 0) return 0;
      if (v > top) return top;
      return v;
   endfunction

   function automatic void plot_pixel(int col, int row, logic on);
      int addr;
      logic [7:0] mask;
      if (col < 0 || row < 0 || col >= SCREEN_WIDTH || row >= SCREEN_HEIGHT) return;
      addr = col + SCREEN_WIDTH * (row >> 3);
      mask = 8'd1 << (row & 7);
      if (on) frame_model[addr] = frame_model[addr] | mask;
      else frame_model[addr] = frame_model[addr] & ~mask;
   endfunction

   function automatic logic sense_pixel(int col, int row);
      int addr;
      if (col < 0 || row < 0 || col >= SCREEN_WIDTH || row >= SCREEN_HEIGHT) return 1'b0;
      addr = col + SCREEN_WIDTH * (row >> 3);
      return frame_model[addr][row & 7];
   endfunction

   function automatic readback_type draw_and_read(draw_req_type r);
      readback_type rb;
      int c0, c1, r0, r1, t;
      rb.pixel_value = 1'b0;
      rb.read_data = 8'd0;
      c0 = clamp_to(int'(r.col_a), SCREEN_WIDTH - 1);
      c1 = clamp_to(int'(r.col_b), SCREEN_WIDTH - 1);
      r0 = clamp_to(int'(r.row_a), SCREEN_HEIGHT - 1);
      r1 = clamp_to(int'(r.row_b), SCREEN_HEIGHT - 1);
      if (c0 > c1) begin
         t = c0; c0 = c1; c1 = t;
      end
      if (r0 > r1) begin
         t = r0; r0 = r1; r1 = t;
      end
      case (r.op)
         OP_SET_PIXEL: plot_pixel(int'(r.col_a), int'(r.row_a), r.draw_value);
         OP_GET_PIXEL: rb.pixel_value = sense_pixel(int'(r.col_a), int'(r.row_a));
         OP_FILL_SCREEN: begin
            for (int i = 0; i < STORE_BYTES; i++)
               frame_model[i] = r.draw_value ? BYTE_ONES : 8'h00;
         end
         OP_FILL_RECT: begin
            for (int c = c0; c <= c1; c++)
               for (int w = r0; w <= r1; w++)
                  plot_pixel(c, w, r.draw_value);
         end
         OP_OUTLINE_RECT: begin
            for (int c = c0; c <= c1; c++) begin
               plot_pixel(c, r0, r.draw_value);
               plot_pixel(c, r1, r.draw_value);
            end
            for (int w = r0; w <= r1; w++) begin
               plot_pixel(c0, w, r.draw_value);
               plot_pixel(c1, w, r.draw_value);
            end
         end
         OP_READ_BYTE: begin
            if (int'(r.byte_index) < STORE_BYTES) rb.read_data = frame_model[r.byte_index];
         end
         default: ;
      endcase
      return rb;
   endfunction

   function automatic void push_req(logic [2:0] op, int ca, int cb, int ra, int rb,
                                    logic v, int idx);
      draw_req_type r;
      r.op = op;
      r.col_a = 16'(ca);
      r.col_b = 16'(cb);
      r.row_a = 16'(ra);
      r.row_b = 16'(rb);
      r.draw_value = v;
      r.byte_index = 10'(idx);
      pending_reqs.push_back(r);
   endfunction

   function automatic int pick_coord(int size);
      int k;
      k = $urandom_range(0, 19);
      if (k == 0) return int'($signed(16'($urandom)));
      if (k < 3) return int'($urandom_range(0, 6)) - 3 + ($urandom_range(0, 1) ? size : 0);
      return int'($urandom_range(0, size - 1));
   endfunction

   function automatic int pick_partner(int base, int span, int size);
      if ($urandom_range(0, 19) == 0) return pick_coord(size);
      return base + int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic void push_random_req();
      int k, ca, ra;
      logic [2:0] op;
      k = $urandom_range(0, 99);
      if (k < 24) op = OP_SET_PIXEL;
      else if (k < 48) op = OP_GET_PIXEL;
      else if (k < 68) op = OP_READ_BYTE;
      else if (k < 81) op = OP_FILL_RECT;
      else if (k < 93) op = OP_OUTLINE_RECT;
      else if (k < 97) op = OP_FILL_SCREEN;
      else op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
      ca = pick_coord(SCREEN_WIDTH);
      ra = pick_coord(SCREEN_HEIGHT);
      push_req(op, ca, pick_partner(ca, 15, SCREEN_WIDTH), ra,
               pick_partner(ra, 20, SCREEN_HEIGHT), 1'($urandom),
               int'($urandom_range(0, 1023)));
   endfunction

   // sender: bursts and gaps, predicts on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_readback.push_back(draw_and_read(on_wire));
            op_count[on_wire.op] = op_count[on_wire.op] + 1;
            items_taken = items_taken + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               on_wire = pending_reqs.pop_front();
               req_tdata <= REQ_DATA_W'({on_wire.byte_index, on_wire.draw_value, on_wire.row_b,
                                         on_wire.row_a, on_wire.col_b, on_wire.col_a});
               req_tuser <= on_wire.op;
               req_tvalid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                           : $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left = burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off once the run is under way
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // receiver: stall pattern and result check
   always @(posedge clock) begin
      readback_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            if (expected_readback.size() == 0) begin
               $error("unexpected result item: %h", rsp_tdata);
               error_count = error_count + 1;
            end else begin
               want = expected_readback.pop_front();
               if (rsp_tdata[0] !== want.pixel_value) begin
                  $error("pixel_value: expected %0d, got %0d", want.pixel_value, rsp_tdata[0]);
                  error_count = error_count + 1;
               end
               if (rsp_tdata[8:1] !== want.read_data) begin
                  $error("read_data: expected %h, got %h", want.read_data, rsp_tdata[8:1]);
                  error_count = error_count + 1;
               end
            end
         end
         ready_cycle <= ready_cycle + 1;
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
         end else begin
            case ((ready_cycle >> 8) & 3)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom);
               2: rsp_tready <= ($urandom_range(0, 9) != 0);
               default: rsp_tready <= ((ready_cycle & 3) != 0);
            endcase
         end
      end
   end

   initial begin
      #40_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      for (int i = 0; i < STORE_BYTES; i++) frame_model[i] = 8'h00;
      for (int i = 0; i < 8; i++) op_count[i] = 0;

      push_req(OP_SET_PIXEL, 0, 0, 0, 0, 1'b1, 0);
      push_req(OP_SET_PIXEL, 127, 0, 63, 0, 1'b1, 0);
      push_req(OP_SET_PIXEL, -1, 0, 10, 0, 1'b1, 0);
      push_req(OP_SET_PIXEL, 128, 0, 10, 0, 1'b1, 0);
      push_req(OP_SET_PIXEL, -32768, 0, 32767, 0, 1'b1, 1023);
      push_req(OP_GET_PIXEL, 0, 0, 0, 0, 1'b0, 0);
      push_req(OP_GET_PIXEL, 127, 0, 63, 0, 1'b0, 0);
      push_req(OP_GET_PIXEL, 0, 0, 64, 0, 1'b0, 0);
      push_req(OP_READ_BYTE, 0, 0, 0, 0, 1'b0, 0);
      push_req(OP_READ_BYTE, 0, 0, 0, 0, 1'b0, 1023);
      // partial span inside one page, corners reversed
      push_req(OP_FILL_RECT, 12, 10, 4, 2, 1'b1, 0);
      push_req(OP_READ_BYTE, 0, 0, 0, 0, 1'b0, 10);
      // span across three pages
      push_req(OP_FILL_RECT, 30, 31, 5, 17, 1'b1, 0);
      push_req(OP_READ_BYTE, 0, 0, 0, 0, 1'b0, 30);
      push_req(OP_READ_BYTE, 0, 0, 0, 0, 1'b0, 286);
      push_req(OP_OUTLINE_RECT, 40, 20, 30, 3, 1'b1, 0);
      push_req(OP_GET_PIXEL, 25, 0, 3, 0, 1'b0, 0);
      push_req(OP_GET_PIXEL, 25, 0, 10, 0, 1'b0, 0);
      // rectangle wholly off screen lands on the nearest edge
      push_req(OP_FILL_RECT, 200, 300, -10, -20, 1'b1, 0);
      push_req(OP_READ_BYTE, 0, 0, 0, 0, 1'b0, 127);
      push_req(OP_SPARE_LO, 5, 9, 5, 9, 1'b1, 127);
      push_req(OP_SPARE_HI, 5, 9, 5, 9, 1'b1, 10);
      push_req(OP_FILL_SCREEN, 0, 0, 0, 0, 1'b1, 0);
      push_req(OP_FILL_RECT, -5, 200, 70, -3, 1'b0, 0);
      push_req(OP_READ_BYTE, 0, 0, 0, 0, 1'b0, 512);

      for (int i = 0; i < RANDOM_ITEMS; i++) push_random_req();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_readback.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_readback.size() != 0) begin
         $error("%0d results still outstanding", expected_readback.size());
         error_count = error_count + 1;
      end

      $display("covered %0d items: %0d set, %0d get, %0d screen fills, %0d rect fills,",
               items_taken, op_count[OP_SET_PIXEL], op_count[OP_GET_PIXEL],
               op_count[OP_FILL_SCREEN], op_count[OP_FILL_RECT]);
      $display("  %0d outlines, %0d byte reads, %0d spare ops; %0d results checked",
               op_count[OP_OUTLINE_RECT], op_count[OP_READ_BYTE],
               op_count[OP_SPARE_LO] + op_count[OP_SPARE_HI], results_seen);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+design
design/pfde_pkg.sv
design/pfde_front.sv
design/pfde_queue.sv
design/pfde_back.sv
design/page_framebuffer_draw_engine_unit.sv
design/pfde_checker.sv
bench/testbench.sv
